>>> sv/bpc_pkg.sv
// Shared constants and codes for the barometric pressure compensation block.
package bpc_pkg;

  // Width of the pipelined restoring divider (one quotient bit per stage)
  localparam int DIV_W = 32;

  // Register stages outside the two dividers
  localparam int FIXED_STAGES = 16;

  // Total latency from input word to output register
  localparam int LAT = FIXED_STAGES + 2 * DIV_W;

  // Configuration register indexes
  localparam logic [2:0] CFG_AC123 = 3'd0;
  localparam logic [2:0] CFG_AC456 = 3'd1;
  localparam logic [2:0] CFG_B12   = 3'd2;
  localparam logic [2:0] CFG_MCMD  = 3'd3;

  // Compensation constants
  localparam logic signed [28:0] B6_OFFSET = 29'sd4000;
  localparam logic [31:0]        X3_BIAS   = 32'd32768;
  localparam logic [15:0]        B7_SCALE  = 16'd50000;
  localparam logic [11:0]        P_SQ_K    = 12'd3038;
  localparam logic signed [13:0] P_LIN_K   = -14'sd7357;
  localparam logic signed [48:0] P_OFS_K   = 49'sd3791;

  // Output limits
  localparam logic signed [25:0] T_MAX = 26'sd32767;
  localparam logic signed [25:0] T_MIN = -26'sd32768;
  localparam logic signed [48:0] P_MAX = 49'sd131071;

endpackage

>>> sv/barometric_pressure_compensation.sv
// Path from accepted input word to output word: 16 register stages plus two 32-stage dividers.
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// The two 32-stage restoring dividers set the depth.
// Reset (synchronous, rst_n low) clears all valid bits and the calibration registers to zero.
module barometric_pressure_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temperature,
  input  logic [15:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_tenths,
  output logic [16:0]        out_pressure_pascal,
  output logic               out_divide_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int W = bpc_pkg::DIV_W;
  localparam int L = bpc_pkg::LAT;

  // Calibration registers
  logic [47:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r, cal_d_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      cal_d_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::CFG_AC123: cal_a_r <= cfg_data;
        bpc_pkg::CFG_AC456: cal_b_r <= cfg_data;
        bpc_pkg::CFG_B12:   cal_c_r <= cfg_data[31:0];
        bpc_pkg::CFG_MCMD:  cal_d_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = $signed(cal_a_r[47:32]);
  assign ac2 = $signed(cal_a_r[31:16]);
  assign ac3 = $signed(cal_a_r[15:0]);
  assign ac4 = cal_b_r[47:32];
  assign ac5 = cal_b_r[31:16];
  assign ac6 = cal_b_r[15:0];
  assign b1  = $signed(cal_c_r[31:16]);
  assign b2  = $signed(cal_c_r[15:0]);
  assign mc  = $signed(cal_d_r[31:16]);
  assign md  = $signed(cal_d_r[15:0]);

  // Global advance and valid chain
  logic         en;
  logic [L-1:0] vld_r;

  assign en        = !vld_r[L-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  // Stage 1: raw word and ut - ac6
  logic [15:0]        s1_up_r;
  logic signed [17:0] s1_diff_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_up_r   <= in_raw_pressure;
      s1_diff_r <= $signed({2'b00, in_raw_temperature}) - $signed({2'b00, ac6});
    end
  end

  // Stage 2: times ac5
  logic [15:0]        s2_up_r;
  logic signed [34:0] s2_prod_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_up_r   <= s1_up_r;
      s2_prod_r <= s1_diff_r * $signed({1'b0, ac5});
    end
  end

  // Stage 3: x1, divisor x1 + md, dividend mc * 2048 as magnitudes
  logic signed [19:0] s3_x1;
  logic signed [20:0] s3_den;
  logic signed [26:0] s3_num;
  logic signed [19:0] s3_x1_r;
  logic [15:0]        s3_up_r;
  logic [26:0]        s3_nmag_r;
  logic [20:0]        s3_dmag_r;
  logic               s3_neg_r, s3_dz_r;

  assign s3_x1  = $signed(s2_prod_r[34:15]);
  assign s3_den = 21'(s3_x1) + 21'(md);
  assign s3_num = $signed({mc, 11'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x1_r   <= s3_x1;
      s3_up_r   <= s2_up_r;
      s3_nmag_r <= s3_num[26] ? 27'(-s3_num) : 27'(s3_num);
      s3_dmag_r <= s3_den[20] ? 21'(-s3_den) : 21'(s3_den);
      s3_neg_r  <= s3_num[26] ^ s3_den[20];
      s3_dz_r   <= (s3_den == '0);
    end
  end

  // Temperature divider and its side data
  logic [31:0] tq;
  bpc_udiv u_tdiv (
    .clk   (clk),
    .en    (en),
    .dvd_i ({5'b0, s3_nmag_r}),
    .dvs_i ({11'b0, s3_dmag_r}),
    .quo_o (tq)
  );

  logic signed [19:0] tsb_x1_r  [W];
  logic [15:0]        tsb_up_r  [W];
  logic               tsb_neg_r [W];
  logic               tsb_dz_r  [W];
  always_ff @(posedge clk) begin
    if (en) begin
      tsb_x1_r[0]  <= s3_x1_r;
      tsb_up_r[0]  <= s3_up_r;
      tsb_neg_r[0] <= s3_neg_r;
      tsb_dz_r[0]  <= s3_dz_r;
      for (int k = 1; k < W; k++) begin
        tsb_x1_r[k]  <= tsb_x1_r[k-1];
        tsb_up_r[k]  <= tsb_up_r[k-1];
        tsb_neg_r[k] <= tsb_neg_r[k-1];
        tsb_dz_r[k]  <= tsb_dz_r[k-1];
      end
    end
  end

  // Stage 4: b5 = x1 + x2
  logic signed [27:0] s4_x2;
  logic signed [28:0] s4_b5_r;
  logic [15:0]        s4_up_r;
  logic               s4_err_r;
  assign s4_x2 = tsb_neg_r[W-1] ? -$signed({1'b0, tq[26:0]}) : $signed({1'b0, tq[26:0]});
  always_ff @(posedge clk) begin
    if (en) begin
      s4_b5_r  <= 29'(tsb_x1_r[W-1]) + 29'(s4_x2);
      s4_up_r  <= tsb_up_r[W-1];
      s4_err_r <= tsb_dz_r[W-1];
    end
  end

  // Stage 5: temperature with saturation, b6
  logic signed [25:0] s5_t;
  logic signed [15:0] s5_t_r;
  logic signed [28:0] s5_b6_r;
  logic [15:0]        s5_up_r;
  logic               s5_err_r;
  assign s5_t = $signed(s4_b5_r[28:4] + 25'(s4_b5_r[3:0] >= 4'd8 ? 1 : 0)) ;
  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_t > bpc_pkg::T_MAX) begin
        s5_t_r <= 16'sh7fff;
      end else if (s5_t < bpc_pkg::T_MIN) begin
        s5_t_r <= -16'sh8000;
      end else begin
        s5_t_r <= s5_t[15:0];
      end
      s5_b6_r  <= s4_b5_r - bpc_pkg::B6_OFFSET;
      s5_up_r  <= s4_up_r;
      s5_err_r <= s4_err_r;
    end
  end

  // Stage 6: b6 squared and the b6 cross products
  logic signed [57:0] s6_sq_r;
  logic signed [44:0] s6_ac2_r, s6_ac3_r;
  logic signed [15:0] s6_t_r;
  logic [15:0]        s6_up_r;
  logic               s6_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_sq_r  <= s5_b6_r * s5_b6_r;
      s6_ac2_r <= ac2 * s5_b6_r;
      s6_ac3_r <= ac3 * s5_b6_r;
      s6_t_r   <= s5_t_r;
      s6_up_r  <= s5_up_r;
      s6_err_r <= s5_err_r;
    end
  end

  // Stage 7: shifts
  logic signed [45:0] s7_sq_r;
  logic signed [33:0] s7_x2a_r;
  logic signed [31:0] s7_x1b_r;
  logic signed [15:0] s7_t_r;
  logic [15:0]        s7_up_r;
  logic               s7_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_sq_r  <= $signed(s6_sq_r[57:12]);
      s7_x2a_r <= $signed(s6_ac2_r[44:11]);
      s7_x1b_r <= $signed(s6_ac3_r[44:13]);
      s7_t_r   <= s6_t_r;
      s7_up_r  <= s6_up_r;
      s7_err_r <= s6_err_r;
    end
  end

  // Stage 8: b2 * sq and b1 * sq
  logic signed [61:0] s8_b2sq_r, s8_b1sq_r;
  logic signed [33:0] s8_x2a_r;
  logic signed [31:0] s8_x1b_r;
  logic signed [15:0] s8_t_r;
  logic [15:0]        s8_up_r;
  logic               s8_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_b2sq_r <= b2 * s7_sq_r;
      s8_b1sq_r <= b1 * s7_sq_r;
      s8_x2a_r  <= s7_x2a_r;
      s8_x1b_r  <= s7_x1b_r;
      s8_t_r    <= s7_t_r;
      s8_up_r   <= s7_up_r;
      s8_err_r  <= s7_err_r;
    end
  end

  // Stage 9: x3 for b3 and for b4
  logic signed [46:0] s9_x3b;
  logic signed [51:0] s9_x3a_r;
  logic signed [44:0] s9_x3b_r;
  logic signed [15:0] s9_t_r;
  logic [15:0]        s9_up_r;
  logic               s9_err_r;
  assign s9_x3b = 47'($signed(s8_b1sq_r[61:16])) + 47'(s8_x1b_r) + 47'sd2;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_x3a_r <= 52'($signed(s8_b2sq_r[61:11])) + 52'(s8_x2a_r);
      s9_x3b_r <= $signed(s9_x3b[46:2]);
      s9_t_r   <= s8_t_r;
      s9_up_r  <= s8_up_r;
      s9_err_r <= s8_err_r;
    end
  end

  // Stage 10: b3 rounded toward zero, up - b3 and x3 + 32768 modulo 2^32
  logic signed [53:0] s10_num;
  logic [31:0]        s10_b3;
  logic [31:0]        s10_upb3_r, s10_c32_r;
  logic signed [15:0] s10_t_r;
  logic               s10_err_r;
  assign s10_num = 54'(ac1) * 54'sd4 + 54'(s9_x3a_r) + 54'sd2;
  assign s10_b3  = s10_num[33:2] + 32'(s10_num[53] && (s10_num[1:0] != 2'b00));
  always_ff @(posedge clk) begin
    if (en) begin
      s10_upb3_r <= {16'b0, s9_up_r} - s10_b3;
      s10_c32_r  <= s9_x3b_r[31:0] + bpc_pkg::X3_BIAS;
      s10_t_r    <= s9_t_r;
      s10_err_r  <= s9_err_r;
    end
  end

  // Stage 11: b4 and b7
  logic [47:0]        s11_b4w, s11_b7w;
  logic [31:0]        s11_b4_r, s11_b7_r;
  logic signed [15:0] s11_t_r;
  logic               s11_err_r;
  assign s11_b4w = ac4 * s10_c32_r;
  assign s11_b7w = s10_upb3_r * bpc_pkg::B7_SCALE;
  always_ff @(posedge clk) begin
    if (en) begin
      s11_b4_r  <= s11_b4w[46:15];
      s11_b7_r  <= s11_b7w[31:0];
      s11_t_r   <= s10_t_r;
      s11_err_r <= s10_err_r;
    end
  end

  // Stage 12: pick dividend form and flag a zero b4
  logic [31:0]        s12_dvd_r, s12_dvs_r;
  logic               s12_hi_r, s12_err_r;
  logic signed [15:0] s12_t_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s12_hi_r  <= s11_b7_r[31];
      s12_dvd_r <= s11_b7_r[31] ? s11_b7_r : {s11_b7_r[30:0], 1'b0};
      s12_dvs_r <= s11_b4_r;
      s12_err_r <= s11_err_r || (s11_b4_r == '0);
      s12_t_r   <= s11_t_r;
    end
  end

  // Pressure divider and its side data
  logic [31:0] pq;
  bpc_udiv u_pdiv (
    .clk   (clk),
    .en    (en),
    .dvd_i (s12_dvd_r),
    .dvs_i (s12_dvs_r),
    .quo_o (pq)
  );

  logic signed [15:0] psb_t_r   [W];
  logic               psb_hi_r  [W];
  logic               psb_err_r [W];
  always_ff @(posedge clk) begin
    if (en) begin
      psb_t_r[0]   <= s12_t_r;
      psb_hi_r[0]  <= s12_hi_r;
      psb_err_r[0] <= s12_err_r;
      for (int k = 1; k < W; k++) begin
        psb_t_r[k]   <= psb_t_r[k-1];
        psb_hi_r[k]  <= psb_hi_r[k-1];
        psb_err_r[k] <= psb_err_r[k-1];
      end
    end
  end

  // Stage 13: p from the quotient
  logic [32:0]        s13_p_r;
  logic signed [15:0] s13_t_r;
  logic               s13_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s13_p_r   <= psb_hi_r[W-1] ? {pq, 1'b0} : {1'b0, pq};
      s13_t_r   <= psb_t_r[W-1];
      s13_err_r <= psb_err_r[W-1];
    end
  end

  // Stage 14: (p >> 8)^2 and -7357 * p
  logic [49:0]        s14_p8sq_r;
  logic signed [47:0] s14_lin_r;
  logic [32:0]        s14_p_r;
  logic signed [15:0] s14_t_r;
  logic               s14_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s14_p8sq_r <= s13_p_r[32:8] * s13_p_r[32:8];
      s14_lin_r  <= $signed({1'b0, s13_p_r}) * bpc_pkg::P_LIN_K;
      s14_p_r    <= s13_p_r;
      s14_t_r    <= s13_t_r;
      s14_err_r  <= s13_err_r;
    end
  end

  // Stage 15: times 3038
  logic [61:0]        s15_sqk_r;
  logic signed [31:0] s15_x2_r;
  logic [32:0]        s15_p_r;
  logic signed [15:0] s15_t_r;
  logic               s15_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s15_sqk_r <= s14_p8sq_r * bpc_pkg::P_SQ_K;
      s15_x2_r  <= $signed(s14_lin_r[47:16]);
      s15_p_r   <= s14_p_r;
      s15_t_r   <= s14_t_r;
      s15_err_r <= s14_err_r;
    end
  end

  // Stage 16: final correction, saturation, output word
  logic signed [48:0] s16_sum, s16_p;
  logic signed [15:0] out_t_r;
  logic [16:0]        out_p_r;
  logic               out_err_r;
  assign s16_sum = $signed({3'b0, s15_sqk_r[61:16]}) + 49'(s15_x2_r) + bpc_pkg::P_OFS_K;
  assign s16_p   = $signed({16'b0, s15_p_r}) + (s16_sum >>> 4);
  always_ff @(posedge clk) begin
    if (en) begin
      out_err_r <= s15_err_r;
      if (s15_err_r) begin
        out_t_r <= '0;
        out_p_r <= '0;
      end else begin
        out_t_r <= s15_t_r;
        if (s16_p < 0) begin
          out_p_r <= '0;
        end else if (s16_p > bpc_pkg::P_MAX) begin
          out_p_r <= '1;
        end else begin
          out_p_r <= s16_p[16:0];
        end
      end
    end
  end

  assign out_temperature_tenths = out_t_r;
  assign out_pressure_pascal    = out_p_r;
  assign out_divide_error       = out_err_r;

endmodule

>>> sv/bpc_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_udiv (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic [31:0] quo_o
);

  localparam int W = bpc_pkg::DIV_W;

  logic [W-1:0] rem_r [W];
  logic [W-1:0] acc_r [W];
  logic [W-1:0] dvs_r [W];
  logic [W-1:0] rem_nxt [W];
  logic [W-1:0] acc_nxt [W];
  logic [W-1:0] dvs_nxt [W];

  // One trial subtract per stage
  always_comb begin
    logic [W-1:0] rin;
    logic [W-1:0] ain;
    logic [W-1:0] din;
    logic [W:0]   trial;
    logic         qbit;
    for (int k = 0; k < W; k++) begin
      if (k == 0) begin
        rin = '0;
        ain = dvd_i;
        din = dvs_i;
      end else begin
        rin = rem_r[k-1];
        ain = acc_r[k-1];
        din = dvs_r[k-1];
      end
      trial = {rin, ain[W-1]};
      qbit  = (trial >= {1'b0, din});
      if (qbit) begin
        rem_nxt[k] = W'(trial - {1'b0, din});
      end else begin
        rem_nxt[k] = trial[W-1:0];
      end
      acc_nxt[k] = {ain[W-2:0], qbit};
      dvs_nxt[k] = din;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k] <= rem_nxt[k];
        acc_r[k] <= acc_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
      end
    end
  end

  assign quo_o = acc_r[W-1];

endmodule
